/* rtl/core/lru_pkg.sv */
// Shared constants and types for the LRU page replacement block.
`timescale 1ns / 1ps

package lru_pkg;

  // Frame set size and significant page number bits
  localparam int unsigned Frames    = 4;
  localparam int unsigned PageBits  = 16;

  // Port widths fixed by the interface
  localparam int unsigned PageW     = 16;
  localparam int unsigned FrameOutW = 6;
  localparam int unsigned CountW    = 32;

  // Derived widths
  localparam int unsigned FrameIdxW = (Frames > 1) ? $clog2(Frames) : 1;
  localparam int unsigned RankW     = (Frames > 1) ? $clog2(Frames) : 1;

  typedef logic [FrameIdxW-1:0] frame_idx_t;
  typedef logic [RankW-1:0]     rank_t;
  typedef logic [PageBits-1:0]  page_t;
  typedef logic [CountW-1:0]    count_t;

  // Outcome of one lookup against the frame table
  typedef struct packed {
    logic       hit;
    logic       evict;
    frame_idx_t frame;
    page_t      evicted_page;
  } lru_access_t;

endpackage

/* rtl/core/lru_page_replacement.sv */
// Path: an accepted input beat is held in the input register, then its result in the result register.
// One page reference per cycle while out_ready_i does not stall the result register; the frame table lookup
// is combinational and its LRU update is registered, so back-to-back references see the updated table.
// Reset (rst_ni low, async): all frames empty, ranks at least recent, counters zero,
// both pipeline registers empty.
`timescale 1ns / 1ps

module lru_page_replacement (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [lru_pkg::PageW-1:0]      page_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic [lru_pkg::FrameOutW-1:0]  frame_index_o,
  output logic                           evicted_valid_o,
  output logic [lru_pkg::PageW-1:0]      evicted_page_o,
  output logic [lru_pkg::CountW-1:0]     fault_count_o,
  output logic [lru_pkg::CountW-1:0]     replace_count_o
);
  import lru_pkg::*;

  logic        s1_valid_q;
  page_t       s1_page_q;
  logic        advance;
  lru_access_t access;
  count_t      fault_next;
  count_t      repl_next;

  logic                 out_valid_q;
  logic                 out_hit_q;
  logic [FrameOutW-1:0] out_frame_q;
  logic                 out_evict_q;
  logic [PageW-1:0]     out_evpage_q;
  count_t               out_fault_q;
  count_t               out_repl_q;

  // Stage 1 moves into the result register when that register is free or drained
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_page_q <= page_i[PageBits-1:0];
    end
  end

  lru_frame_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (advance),
    .page_i   (s1_page_q),
    .access_o (access)
  );

  lru_stat_counters u_counters (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .upd_i          (advance),
    .fault_i        (!access.hit),
    .replace_i      (access.evict),
    .fault_next_o   (fault_next),
    .replace_next_o (repl_next)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_hit_q    <= access.hit;
      out_frame_q  <= FrameOutW'(access.frame);
      out_evict_q  <= access.evict;
      out_evpage_q <= PageW'(access.evicted_page);
      out_fault_q  <= fault_next;
      out_repl_q   <= repl_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign frame_index_o   = out_frame_q;
  assign evicted_valid_o = out_evict_q;
  assign evicted_page_o  = out_evpage_q;
  assign fault_count_o   = out_fault_q;
  assign replace_count_o = out_repl_q;

endmodule

/* rtl/core/lru_frame_table.sv */
// Frame table: page tags, valid flags, recency ranks, lookup and LRU update.
`timescale 1ns / 1ps

module lru_frame_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 upd_i,
  input  lru_pkg::page_t       page_i,
  output lru_pkg::lru_access_t access_o
);
  import lru_pkg::*;

  logic [Frames-1:0] valid_q, valid_d;
  page_t             page_q [Frames];
  page_t             page_d [Frames];
  rank_t             rank_q [Frames];
  rank_t             rank_d [Frames];

  logic [Frames-1:0] match;
  logic              hit;
  logic              any_empty;
  frame_idx_t        hit_idx;
  frame_idx_t        empty_idx;
  frame_idx_t        victim;
  frame_idx_t        sel;
  rank_t             old_rank;

  // Tag compare against every valid frame
  always_comb begin
    for (int j = 0; j < Frames; j++) begin
      match[j] = valid_q[j] && (page_q[j] == page_i);
    end
  end

  // Lowest-index hit and lowest-index empty frame
  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    any_empty = 1'b0;
    empty_idx = '0;
    for (int j = Frames - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit     = 1'b1;
        hit_idx = frame_idx_t'(j);
      end
      if (!valid_q[j]) begin
        any_empty = 1'b1;
        empty_idx = frame_idx_t'(j);
      end
    end
  end

  // Victim: highest rank, ties go to the lower index
  always_comb begin
    victim = '0;
    for (int j = 1; j < Frames; j++) begin
      if (rank_q[j] > rank_q[victim]) begin
        victim = frame_idx_t'(j);
      end
    end
  end

  // Frame that holds the page after this access
  always_comb begin
    priority if (hit) begin
      sel = hit_idx;
    end else if (any_empty) begin
      sel = empty_idx;
    end else begin
      sel = victim;
    end
  end

  // An empty frame counts as least recent
  assign old_rank = valid_q[sel] ? rank_q[sel] : rank_t'(Frames - 1);

  assign access_o.hit          = hit;
  assign access_o.evict        = !hit && !any_empty;
  assign access_o.frame        = sel;
  assign access_o.evicted_page = (!hit && !any_empty) ? page_q[victim] : '0;

  // Next table state: age the more recent frames, refresh the accessed one
  always_comb begin
    valid_d = valid_q;
    for (int j = 0; j < Frames; j++) begin
      page_d[j] = page_q[j];
      rank_d[j] = rank_q[j];
    end
    if (upd_i) begin
      for (int j = 0; j < Frames; j++) begin
        if ((frame_idx_t'(j) != sel) && valid_q[j] && (rank_q[j] < old_rank)) begin
          rank_d[j] = rank_q[j] + rank_t'(1);
        end
      end
      rank_d[sel]  = '0;
      valid_d[sel] = 1'b1;
      if (!hit) begin
        page_d[sel] = page_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int j = 0; j < Frames; j++) begin
        page_q[j] <= '0;
        rank_q[j] <= rank_t'(Frames - 1);
      end
    end else begin
      valid_q <= valid_d;
      for (int j = 0; j < Frames; j++) begin
        page_q[j] <= page_d[j];
        rank_q[j] <= rank_d[j];
      end
    end
  end

`ifndef SYNTHESIS
  // A page is resident in at most one frame
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("page resident in more than one frame");

  // The accessed frame becomes most recent
  a_mru_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i |=> (rank_q[$past(sel)] == '0))
    else $error("accessed frame not at rank zero");

  // A fault installs the new page in the chosen frame
  a_fill_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_i && !hit) |=> (page_q[$past(sel)] == $past(page_i)))
    else $error("faulting page not installed");

  // Frames never go empty once filled
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((valid_q & $past(valid_q)) == $past(valid_q)))
    else $error("filled frame lost its valid flag");
`endif

endmodule

/* rtl/core/lru_stat_counters.sv */
// Saturating fault and replacement counters.
`timescale 1ns / 1ps

module lru_stat_counters (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            upd_i,
  input  logic            fault_i,
  input  logic            replace_i,
  output lru_pkg::count_t fault_next_o,
  output lru_pkg::count_t replace_next_o
);
  import lru_pkg::*;

  count_t fault_q, fault_d;
  count_t repl_q, repl_d;

  // Increment on event, hold at all ones
  always_comb begin
    fault_d = fault_q;
    repl_d  = repl_q;
    if (upd_i && fault_i && (fault_q != '1)) begin
      fault_d = fault_q + count_t'(1);
    end
    if (upd_i && replace_i && (repl_q != '1)) begin
      repl_d = repl_q + count_t'(1);
    end
  end

  assign fault_next_o   = fault_d;
  assign replace_next_o = repl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q <= '0;
      repl_q  <= '0;
    end else begin
      fault_q <= fault_d;
      repl_q  <= repl_d;
    end
  end

endmodule
